>>> rtl/hfe_pkg.sv
// Shared types, constants and the CRC byte update for the HDLC frame encoder.
package hfe_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [2:0]  STUFF_RUN = 3'd5;
    localparam int          CMD_DEPTH = 2;

    // One classified byte handed from the front to the serializer
    typedef struct packed {
        logic        sof;
        logic        eof;
        logic [7:0]  data;
        logic [15:0] fcs;
    } t_cmd;

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/hfe_front.sv
// Front end: accepts frame bytes, runs the CRC and classifies each byte into a command.
module hfe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_frame,
    input  logic          i_cmd_full,
    output logic          o_full,
    output logic          o_cmd_push,
    output hfe_pkg::t_cmd o_cmd
);
    import hfe_pkg::*;

    logic        r_fcs_cmp;
    logic        r_in_frame;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [15:0] crc_base;

    // Restart the CRC on the first byte of a frame
    assign crc_base   = r_in_frame ? r_crc : CRC_INIT;
    assign n_crc      = crc_byte(crc_base, i_data_byte);
    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push && !i_cmd_full;

    // Build the command for the serializer
    always_comb begin
        o_cmd.sof  = !r_in_frame;
        o_cmd.eof  = i_end_of_frame;
        o_cmd.data = i_data_byte;
        o_cmd.fcs  = r_fcs_cmp ? ~n_crc : n_crc;
    end

    // Track frame state and the running CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcs_cmp  <= 1'b1;
            r_in_frame <= 1'b0;
            r_crc      <= CRC_INIT;
        end else begin
            if (i_cfg_we) begin
                r_fcs_cmp <= i_cfg_wdata;
            end
            if (o_cmd_push) begin
                if (i_end_of_frame) begin
                    r_in_frame <= 1'b0;
                    r_crc      <= CRC_INIT;
                end else begin
                    r_in_frame <= 1'b1;
                    r_crc      <= n_crc;
                end
            end
        end
    end

endmodule

>>> rtl/hfe_cmd_fifo.sv
// Short command queue between the front end and the serializer.
module hfe_cmd_fifo #(
    parameter int DEPTH = hfe_pkg::CMD_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hfe_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output hfe_pkg::t_cmd o_head
);
    import hfe_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/hfe_serializer.sv
// Back end: serializes flags, data and FCS one line bit per cycle while pop takes each beat, with bit stuffing.
module hfe_serializer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  hfe_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_line_bit,
    output logic          o_is_flag,
    output logic          o_is_stuffed,
    output logic          o_last_of_run
);
    import hfe_pkg::*;

    localparam logic [2:0] SEG_OPEN   = 3'd0;
    localparam logic [2:0] SEG_DATA   = 3'd1;
    localparam logic [2:0] SEG_FCS_LO = 3'd2;
    localparam logic [2:0] SEG_FCS_HI = 3'd3;
    localparam logic [2:0] SEG_CLOSE  = 3'd4;

    t_cmd       r_cmd;
    logic       r_busy;
    logic [2:0] r_seg;
    logic [2:0] r_idx;
    logic [2:0] r_ones;
    logic       r_stuff_pending;
    logic       r_stuff_last;
    logic       r_out_valid;
    logic       r_line_bit;
    logic       r_is_flag;
    logic       r_is_stuffed;
    logic       r_last_of_run;

    logic       cur_bit;
    logic       flag_seg;
    logic [2:0] ones_inc;
    logic       stuff_need;
    logic       final_pos;
    logic [2:0] n_seg;
    logic       advance;
    logic       emit;
    logic       done;
    logic       load;

    // Select the current bit and the segment that follows
    always_comb begin
        cur_bit  = 1'b0;
        flag_seg = 1'b0;
        n_seg    = SEG_CLOSE;
        unique case (r_seg)
            SEG_OPEN: begin
                cur_bit  = FLAG_BYTE[r_idx];
                flag_seg = 1'b1;
                n_seg    = SEG_DATA;
            end
            SEG_DATA: begin
                cur_bit = r_cmd.data[r_idx];
                n_seg   = SEG_FCS_LO;
            end
            SEG_FCS_LO: begin
                cur_bit = r_cmd.fcs[{1'b0, r_idx}];
                n_seg   = SEG_FCS_HI;
            end
            SEG_FCS_HI: begin
                cur_bit = r_cmd.fcs[{1'b1, r_idx}];
                n_seg   = SEG_CLOSE;
            end
            SEG_CLOSE: begin
                cur_bit  = FLAG_BYTE[r_idx];
                flag_seg = 1'b1;
                n_seg    = SEG_CLOSE;
            end
            default: begin
                cur_bit  = 1'b0;
                flag_seg = 1'b0;
                n_seg    = SEG_CLOSE;
            end
        endcase
    end

    // Stuffing decision and end-of-command detection
    assign ones_inc   = cur_bit ? r_ones + 3'd1 : 3'd0;
    assign stuff_need = !flag_seg && (ones_inc == STUFF_RUN);
    assign final_pos  = (r_idx == 3'd7) &&
                        ((r_seg == SEG_CLOSE) || ((r_seg == SEG_DATA) && !r_cmd.eof));
    assign advance    = !r_out_valid || i_pop;
    assign emit       = r_busy && advance;
    assign done       = emit && (r_stuff_pending ? r_stuff_last : (final_pos && !stuff_need));
    assign load       = i_cmd_valid && (!r_busy || done);
    assign o_cmd_pop  = load;

    assign o_empty       = !r_out_valid;
    assign o_line_bit    = r_line_bit;
    assign o_is_flag     = r_is_flag;
    assign o_is_stuffed  = r_is_stuffed;
    assign o_last_of_run = r_last_of_run;

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_stuff_pending) begin
                r_line_bit    <= 1'b0;
                r_is_flag     <= 1'b0;
                r_is_stuffed  <= 1'b1;
                r_last_of_run <= r_stuff_last;
            end else begin
                r_line_bit    <= cur_bit;
                r_is_flag     <= flag_seg;
                r_is_stuffed  <= 1'b0;
                r_last_of_run <= final_pos && !stuff_need;
            end
        end
        if (load) begin
            r_cmd <= i_cmd;
        end
        if (emit && !r_stuff_pending) begin
            r_stuff_last <= final_pos;
        end
    end

    // Sequence through the segments of each command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_seg           <= SEG_OPEN;
            r_idx           <= '0;
            r_ones          <= '0;
            r_stuff_pending <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                if (r_stuff_pending) begin
                    r_stuff_pending <= 1'b0;
                    r_ones          <= '0;
                end else begin
                    r_stuff_pending <= stuff_need;
                    if (final_pos && (r_seg == SEG_CLOSE)) begin
                        r_ones <= '0;
                    end else if (!flag_seg) begin
                        r_ones <= stuff_need ? 3'd0 : ones_inc;
                    end
                end
            end else if (advance) begin
                r_out_valid <= 1'b0;
            end
            // Start the next command, or step the bit position
            if (load) begin
                r_busy <= 1'b1;
                r_seg  <= i_cmd.sof ? SEG_OPEN : SEG_DATA;
                r_idx  <= '0;
            end else begin
                if (done) begin
                    r_busy <= 1'b0;
                end
                if (emit && !r_stuff_pending) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        r_seg <= n_seg;
                    end
                end
            end
        end
    end

endmodule

>>> rtl/hdlc_frame_encoder.sv
// Top level of the HDLC frame encoder: front end, command queue and bit serializer.
//
// Bytes go in on push/full with an end-of-frame mark; line bits come out one per
// beat on empty/pop, LSB first, with flags, bit stuffing and a CRC-16 FCS. The
// serializer sends one line bit per clock while pop takes each beat; a byte inside
// a frame sends 8 data bits plus up to two stuffed zeros, the first byte of a frame
// also the 8-bit opening flag, and the last byte its data and FCS (24 bits with at
// most five stuffed zeros) and the closing flag; a one-byte frame sends up to 44
// line bits. A byte that reaches an idle serializer is first loaded into a register.
// The front end computes the CRC in the cycle a byte is accepted and parks it in a
// queue of CmdDepth commands, so push is taken while the serializer is still
// sending earlier bytes; full rises only when that queue is full. A stalled pop
// holds the current beat and lets the serializer finish nothing further until it
// is taken. i_cfg_wdata written with i_cfg_we selects the ones-complement FCS (1,
// reset value) or the raw CRC (0); write it only while no frame is in progress.
module hdlc_frame_encoder #(
    parameter int CmdDepth = hfe_pkg::CMD_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_frame,
    output logic       empty,
    input  logic       pop,
    output logic       o_line_bit,
    output logic       o_is_flag,
    output logic       o_is_stuffed,
    output logic       o_last_of_run
);
    import hfe_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic front_push;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;

    // Accept and classify bytes
    hfe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (push),
        .i_data_byte   (i_data_byte),
        .i_end_of_frame(i_end_of_frame),
        .i_cmd_full    (cmd_full),
        .o_full        (full),
        .o_cmd_push    (front_push),
        .o_cmd         (front_cmd)
    );

    // Decouple front and back
    hfe_cmd_fifo #(
        .DEPTH(CmdDepth)
    ) u_cmd_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_cmd  (front_cmd),
        .i_pop  (cmd_pop),
        .o_full (cmd_full),
        .o_empty(cmd_empty),
        .o_head (head_cmd)
    );

    // Serialize onto the line
    hfe_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (!cmd_empty),
        .i_cmd        (head_cmd),
        .o_cmd_pop    (cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_line_bit   (o_line_bit),
        .o_is_flag    (o_is_flag),
        .o_is_stuffed (o_is_stuffed),
        .o_last_of_run(o_last_of_run)
    );

endmodule

>>> rtl/hfe_checker.sv
// Port-level checks for the HDLC frame encoder, bound to the top level.
module hfe_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_full,
    input logic i_empty,
    input logic i_pop,
    input logic i_line_bit,
    input logic i_is_flag,
    input logic i_is_stuffed,
    input logic i_last_of_run
);

    // A stuffed beat is always a zero and never part of a flag
    a_stuff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_is_stuffed) |-> (!i_line_bit && !i_is_flag))
        else $error("stuffed beat is not a plain zero");

    // A flag ending a run is the closing flag, whose last bit is zero
    a_flag_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_is_flag && i_last_of_run) |-> !i_line_bit)
        else $error("closing flag ends on a one");

    // Reset leaves both queues drained
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_empty && !i_full))
        else $error("encoder not idle after reset");

    // A stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_line_bit) && $stable(i_is_flag)
            && $stable(i_is_stuffed) && $stable(i_last_of_run)))
        else $error("stalled beat changed");

endmodule

bind hdlc_frame_encoder hfe_checker u_hfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_full       (full),
    .i_empty      (empty),
    .i_pop        (pop),
    .i_line_bit   (o_line_bit),
    .i_is_flag    (o_is_flag),
    .i_is_stuffed (o_is_stuffed),
    .i_last_of_run(o_last_of_run)
);

>>> bench/hdlc_frame_encoder_checker.sv
// Line-bit predictor and scoreboard for the HDLC frame encoder bench.
`timescale 1ns / 100ps

module hdlc_frame_encoder_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_frame,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic       i_line_bit,
    input  logic       i_is_flag,
    input  logic       i_is_stuffed,
    input  logic       i_last_of_run,
    output int         o_error_count,
    output int         o_beats_pending
);

    typedef struct packed {
        logic line_bit;
        logic is_flag;
        logic is_stuffed;
        logic last_of_run;
    } t_line_beat;

    // Expected line bits, oldest first
    t_line_beat line_beats_q[$];

    // Encoder state as seen from outside
    logic        fcs_invert;
    logic [15:0] frame_crc;
    logic [2:0]  ones_run;
    logic        frame_open;
    int          mismatches;

    // Advance the reflected CRC one data bit at a time
    function automatic logic [15:0] crc_advance(input logic [15:0] crc, input logic [7:0] value);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ value[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ hfe_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic queue_beat(input logic b, input logic flag, input logic stuffed);
        t_line_beat beat;
        beat.line_bit    = b;
        beat.is_flag     = flag;
        beat.is_stuffed  = stuffed;
        beat.last_of_run = 1'b0;
        line_beats_q.insert(line_beats_q.size(), beat);
    endtask

    // Flags go out raw and leave the ones run alone
    task automatic queue_flag();
        for (int i = 0; i < 8; i++) begin
            queue_beat(hfe_pkg::FLAG_BYTE[i], 1'b1, 1'b0);
        end
    endtask

    // Send LSB first, inserting a zero after five ones in a row
    task automatic queue_stuffed_byte(input logic [7:0] value);
        for (int i = 0; i < 8; i++) begin
            ones_run = value[i] ? ones_run + 3'd1 : 3'd0;
            queue_beat(value[i], 1'b0, 1'b0);
            if (ones_run >= hfe_pkg::STUFF_RUN) begin
                queue_beat(1'b0, 1'b0, 1'b1);
                ones_run = 3'd0;
            end
        end
    endtask

    // Expand one accepted byte into its line bits
    task automatic encode_byte(input logic [7:0] value, input logic eof);
        logic [15:0] fcs;
        t_line_beat  tail;
        if (!frame_open) begin
            frame_crc  = hfe_pkg::CRC_INIT;
            ones_run   = 3'd0;
            queue_flag();
            frame_open = 1'b1;
        end
        frame_crc = crc_advance(frame_crc, value);
        queue_stuffed_byte(value);
        if (eof) begin
            fcs = fcs_invert ? ~frame_crc : frame_crc;
            queue_stuffed_byte(fcs[7:0]);
            queue_stuffed_byte(fcs[15:8]);
            queue_flag();
            frame_open = 1'b0;
            frame_crc  = hfe_pkg::CRC_INIT;
            ones_run   = 3'd0;
        end
        // Mark the final beat of this byte
        tail = line_beats_q[line_beats_q.size() - 1];
        tail.last_of_run = 1'b1;
        line_beats_q[line_beats_q.size() - 1] = tail;
    endtask

    task automatic compare_field(input string name, input logic expected, input logic actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %b, got %b", $time, name, expected, actual);
            mismatches++;
        end
    endtask

    // Match one output beat against the oldest prediction
    task automatic check_beat();
        t_line_beat want;
        if (line_beats_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got bit %b flag %b stuff %b last %b",
                     $time, i_line_bit, i_is_flag, i_is_stuffed, i_last_of_run);
            mismatches++;
        end else begin
            want = line_beats_q.pop_front();
            compare_field("line_bit", want.line_bit, i_line_bit);
            compare_field("is_flag", want.is_flag, i_is_flag);
            compare_field("is_stuffed", want.is_stuffed, i_is_stuffed);
            compare_field("last_of_run", want.last_of_run, i_last_of_run);
        end
    endtask

    initial begin
        fcs_invert      = 1'b1;
        frame_crc       = hfe_pkg::CRC_INIT;
        ones_run        = 3'd0;
        frame_open      = 1'b0;
        mismatches      = 0;
        o_error_count   = 0;
        o_beats_pending = 0;
    end

    // Predict on input beats, then check output beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fcs_invert = 1'b1;
            frame_crc  = hfe_pkg::CRC_INIT;
            ones_run   = 3'd0;
            frame_open = 1'b0;
            line_beats_q.delete();
        end else begin
            if (i_cfg_we) begin
                fcs_invert = i_cfg_wdata;
            end
            if (i_push && !i_full) begin
                encode_byte(i_data_byte, i_end_of_frame);
            end
            if (i_pop && !i_empty) begin
                check_beat();
            end
        end
        o_error_count   <= mismatches;
        o_beats_pending <= line_beats_q.size();
    end

endmodule

>>> bench/hdlc_frame_encoder_tb.sv
// Stimulus and verdict for the HDLC frame encoder bench.
`timescale 1ns / 100ps

module hdlc_frame_encoder_tb;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_wdata;
    logic       push;
    logic       full;
    logic [7:0] i_data_byte;
    logic       i_end_of_frame;
    logic       empty;
    logic       pop;
    logic       o_line_bit;
    logic       o_is_flag;
    logic       o_is_stuffed;
    logic       o_last_of_run;
    int         error_count;
    int         beats_pending;
    logic       sender_calm;
    logic       sink_calm;

    hdlc_frame_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_end_of_frame (i_end_of_frame),
        .empty          (empty),
        .pop            (pop),
        .o_line_bit     (o_line_bit),
        .o_is_flag      (o_is_flag),
        .o_is_stuffed   (o_is_stuffed),
        .o_last_of_run  (o_last_of_run)
    );

    hdlc_frame_encoder_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_push          (push),
        .i_full          (full),
        .i_data_byte     (i_data_byte),
        .i_end_of_frame  (i_end_of_frame),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_line_bit      (o_line_bit),
        .i_is_flag       (o_is_flag),
        .i_is_stuffed    (o_is_stuffed),
        .i_last_of_run   (o_last_of_run),
        .o_error_count   (error_count),
        .o_beats_pending (beats_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the encoder hangs
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drive one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] value, input logic eof);
        int gap;
        if ($urandom_range(0, 11) == 0) begin
            sender_calm = ~sender_calm;
        end
        gap = sender_calm ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data_byte    = value;
        i_end_of_frame = eof;
        push           = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    // Favor bytes that exercise flags and stuffing
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'hFF;
            1: return hfe_pkg::FLAG_BYTE;
            2: return 8'h00;
            3: return 8'hF8 | 8'($urandom_range(0, 7));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send whole frames of random content, mostly short ones
    task automatic send_random_frames(input int nbytes);
        int sent;
        int len;
        sent = 0;
        while (sent < nbytes) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 4);
            for (int j = 0; j < len; j++) begin
                send_byte(pick_byte(), j == len - 1);
            end
            sent += len;
        end
    endtask

    // Change the FCS mode only once every predicted beat is out
    task automatic set_fcs_mode(input logic invert);
        while (beats_pending != 0) @(negedge i_clk);
        i_cfg_wdata = invert;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Pop side: random stalls per beat, with stall-free stretches
    initial begin
        int stall;
        pop = 1'b0;
        sink_calm = 1'b1;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                sink_calm = ~sink_calm;
            end
            stall = sink_calm ? $urandom_range(0, 18) : 0;
            if (stall > 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop = 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        push           = 1'b0;
        i_data_byte    = 8'h00;
        i_end_of_frame = 1'b0;
        sender_calm    = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames with the reset FCS mode (complemented)
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(hfe_pkg::FLAG_BYTE, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);

        // Directed frames with the raw CRC
        set_fcs_mode(1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);

        send_random_frames(40);
        set_fcs_mode(1'b1);
        send_random_frames(40);

        // Drain, then allow the longest run of one byte to settle
        while (beats_pending != 0) @(negedge i_clk);
        repeat (60) @(posedge i_clk);

        if (error_count == 0 && beats_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
